// ===== hdl/rsws_pkg.sv =====
// Shared types and fixed field widths for the reservation station wakeup/select block.
// Has no dependencies. Used by reservation_station_wakeup_select.
package rsws_pkg;

	// Operation codes carried by each input item.
	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_WAKE  = 2'd1,
		OP_ISSUE = 2'd2,
		OP_FLUSH = 2'd3
	} op_t;

	// Fixed widths of the operand, instruction detail and slot fields.
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned INFO_W = 26;
	localparam int unsigned SLOT_W = 4;

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [INFO_W-1:0] info_t;
	typedef logic [SLOT_W-1:0] slot_t;

endpackage

// ===== hdl/reservation_station_wakeup_select.sv =====
// Reservation station issue queue: allocate, tag wakeup, lowest-index select and flush.
// Depends on rsws_pkg for the operation codes and fixed field widths.
//
// An item is taken whenever start is high; busy is held low, so one item is accepted in
// every cycle. The item is registered, then combinational logic (priority search for the
// lowest free slot, tag compare across all entries, priority search for the lowest ready
// entry) updates the entry array and loads the result register. Each item's result is
// therefore on the result ports, with done high, once the result register holds it, and
// results come out in order, one result per item. The receiver cannot stall: done is high
// for exactly one cycle per result. Reset frees every entry at once; no clearing pass is
// needed.
module reservation_station_wakeup_select #(
	parameter int unsigned ENTRIES  = 16,
	parameter int unsigned TAG_BITS = 7,
	parameter int unsigned ROB_BITS = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  rsws_pkg::op_t          op,
	input  logic [TAG_BITS-1:0]    tag_a,
	input  rsws_pkg::val_t         value_a,
	input  logic                   ready_a,
	input  logic [TAG_BITS-1:0]    tag_b,
	input  rsws_pkg::val_t         value_b,
	input  logic                   ready_b,
	input  rsws_pkg::info_t        op_info,
	input  logic [ROB_BITS-1:0]    rob_id,
	input  logic [TAG_BITS-1:0]    result_tag,
	input  rsws_pkg::val_t         result_value,
	output logic                   done,
	output logic                   ok,
	output rsws_pkg::slot_t        slot,
	output rsws_pkg::val_t         issued_value_a,
	output rsws_pkg::val_t         issued_value_b,
	output logic [ROB_BITS-1:0]    issued_rob_id,
	output rsws_pkg::info_t        issued_op_info,
	output logic                   has_free_slot
);
	import rsws_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES);

	// Input register.
	logic                start_s1;
	op_t                 op_s1;
	logic [TAG_BITS-1:0] tag_a_s1;
	val_t                value_a_s1;
	logic                ready_a_s1;
	logic [TAG_BITS-1:0] tag_b_s1;
	val_t                value_b_s1;
	logic                ready_b_s1;
	info_t               op_info_s1;
	logic [ROB_BITS-1:0] rob_id_s1;
	logic [TAG_BITS-1:0] result_tag_s1;
	val_t                result_value_s1;

	// Entry array.
	logic [ENTRIES-1:0]  valid_q;
	logic [ENTRIES-1:0]  rdy_a_q;
	logic [ENTRIES-1:0]  rdy_b_q;
	logic [TAG_BITS-1:0] wtag_a_q [ENTRIES];
	logic [TAG_BITS-1:0] wtag_b_q [ENTRIES];
	val_t                opnd_a_q [ENTRIES];
	val_t                opnd_b_q [ENTRIES];
	logic [ROB_BITS-1:0] rob_q    [ENTRIES];
	info_t               info_q   [ENTRIES];

	// Next-state and result logic.
	logic [ENTRIES-1:0]  valid_d;
	logic [ENTRIES-1:0]  rdy_a_d;
	logic [ENTRIES-1:0]  rdy_b_d;
	logic [ENTRIES-1:0]  wake_a;
	logic [ENTRIES-1:0]  wake_b;
	logic                alloc_hit;
	logic [IDX_W-1:0]    alloc_idx;
	logic                issue_hit;
	logic [IDX_W-1:0]    issue_idx;
	logic                do_alloc;
	logic                do_issue;
	logic                do_wake;
	logic                ok_d;
	slot_t               slot_d;

	// The block never holds off an item.
	assign busy = 1'b0;

	// Register the incoming item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
		end else begin
			start_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1           <= op;
		tag_a_s1        <= tag_a;
		value_a_s1      <= value_a;
		ready_a_s1      <= ready_a;
		tag_b_s1        <= tag_b;
		value_b_s1      <= value_b;
		ready_b_s1      <= ready_b;
		op_info_s1      <= op_info;
		rob_id_s1       <= rob_id;
		result_tag_s1   <= result_tag;
		result_value_s1 <= result_value;
	end

	// Priority searches for the lowest free slot and the lowest ready entry.
	always_comb begin
		alloc_hit = 1'b0;
		alloc_idx = '0;
		issue_hit = 1'b0;
		issue_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!alloc_hit && !valid_q[i]) begin
				alloc_hit = 1'b1;
				alloc_idx = IDX_W'(i);
			end
			if (!issue_hit && valid_q[i] && rdy_a_q[i] && rdy_b_q[i]) begin
				issue_hit = 1'b1;
				issue_idx = IDX_W'(i);
			end
		end
	end

	// Tag match of the broadcast result against every waiting operand.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			wake_a[i] = valid_q[i] && !rdy_a_q[i] && (wtag_a_q[i] == result_tag_s1);
			wake_b[i] = valid_q[i] && !rdy_b_q[i] && (wtag_b_q[i] == result_tag_s1);
		end
	end

	assign do_alloc = start_s1 && (op_s1 == OP_ALLOC) && alloc_hit;
	assign do_issue = start_s1 && (op_s1 == OP_ISSUE) && issue_hit;
	assign do_wake  = start_s1 && (op_s1 == OP_WAKE);

	// Next state of the valid and ready bits.
	always_comb begin
		valid_d = valid_q;
		rdy_a_d = rdy_a_q;
		rdy_b_d = rdy_b_q;
		if (start_s1) begin
			case (op_s1)
				OP_ALLOC: begin
					if (alloc_hit) begin
						valid_d[alloc_idx] = 1'b1;
						rdy_a_d[alloc_idx] = ready_a_s1;
						rdy_b_d[alloc_idx] = ready_b_s1;
					end
				end
				OP_WAKE: begin
					rdy_a_d = rdy_a_q | wake_a;
					rdy_b_d = rdy_b_q | wake_b;
				end
				OP_ISSUE: begin
					if (issue_hit) begin
						valid_d[issue_idx] = 1'b0;
					end
				end
				OP_FLUSH: begin
					valid_d = '0;
				end
				default: begin
					valid_d = valid_q;
				end
			endcase
		end
	end

	// Result fields that depend on the operation.
	always_comb begin
		ok_d   = do_alloc || do_issue;
		slot_d = '0;
		if (do_alloc) begin
			slot_d = SLOT_W'(alloc_idx);
		end else if (do_issue) begin
			slot_d = SLOT_W'(issue_idx);
		end
	end

	// Control bits of the entry array.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdy_a_q <= '0;
			rdy_b_q <= '0;
		end else begin
			valid_q <= valid_d;
			rdy_a_q <= rdy_a_d;
			rdy_b_q <= rdy_b_d;
		end
	end

	// Payload of the entry array: written on allocate, operands also captured on wakeup.
	always_ff @(posedge clk) begin
		if (do_alloc) begin
			wtag_a_q[alloc_idx] <= tag_a_s1;
			wtag_b_q[alloc_idx] <= tag_b_s1;
			opnd_a_q[alloc_idx] <= value_a_s1;
			opnd_b_q[alloc_idx] <= value_b_s1;
			rob_q[alloc_idx]    <= rob_id_s1;
			info_q[alloc_idx]   <= op_info_s1;
		end
		if (do_wake) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (wake_a[i]) begin
					opnd_a_q[i] <= result_value_s1;
				end
				if (wake_b[i]) begin
					opnd_b_q[i] <= result_value_s1;
				end
			end
		end
	end

	// Result register: the strobe is reset, the fields are not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= start_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok            <= ok_d;
		slot          <= slot_d;
		has_free_slot <= !(&valid_d);
		if (do_issue) begin
			issued_value_a <= opnd_a_q[issue_idx];
			issued_value_b <= opnd_b_q[issue_idx];
			issued_rob_id  <= rob_q[issue_idx];
			issued_op_info <= info_q[issue_idx];
		end else begin
			issued_value_a <= '0;
			issued_value_b <= '0;
			issued_rob_id  <= '0;
			issued_op_info <= '0;
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the reservation station wakeup/select block.
// Depends on rsws_pkg and reservation_station_wakeup_select; a directed table is followed by
// random items, and every result is checked against a predictor of the entry array.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rsws_pkg::*;

	localparam int ENTRY_N    = 16;
	localparam int TAG_W      = 7;
	localparam int ROB_W      = 5;
	localparam int RAND_ITEMS = 1650;
	localparam int QUIET_MAX  = 2000;

	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [ROB_W-1:0] rob_t;

	// One input item, in port order.
	typedef struct packed {
		op_t   op;
		tag_t  tag_a;
		val_t  value_a;
		logic  ready_a;
		tag_t  tag_b;
		val_t  value_b;
		logic  ready_b;
		info_t op_info;
		rob_t  rob_id;
		tag_t  result_tag;
		val_t  result_value;
	} request_t;

	// One result item.
	typedef struct packed {
		logic  ok;
		slot_t slot;
		val_t  val_a;
		val_t  val_b;
		rob_t  rob;
		info_t info;
		logic  free;
	} outcome_t;

	// One slot of the station as the predictor keeps it.
	typedef struct packed {
		logic  held;
		logic  rdy_a;
		tag_t  tag_a;
		val_t  val_a;
		logic  rdy_b;
		tag_t  tag_b;
		val_t  val_b;
		rob_t  rob;
		info_t info;
	} entry_t;

	typedef struct packed {
		request_t   rq;
		logic [4:0] reps;
		logic       typed;
		outcome_t   want;
	} row_t;

	typedef struct {
		outcome_t res;
		realtime  at;
	} pending_t;

	localparam outcome_t UNTYPED = '0;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	request_t stim;
	outcome_t got;

	entry_t   station [ENTRY_N];
	pending_t awaited [$];
	int       mismatches;
	int       idle_pct;
	row_t     directed_rows [25];

	reservation_station_wakeup_select #(
		.ENTRIES (ENTRY_N),
		.TAG_BITS(TAG_W),
		.ROB_BITS(ROB_W)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (stim.op),
		.tag_a         (stim.tag_a),
		.value_a       (stim.value_a),
		.ready_a       (stim.ready_a),
		.tag_b         (stim.tag_b),
		.value_b       (stim.value_b),
		.ready_b       (stim.ready_b),
		.op_info       (stim.op_info),
		.rob_id        (stim.rob_id),
		.result_tag    (stim.result_tag),
		.result_value  (stim.result_value),
		.done          (done),
		.ok            (got.ok),
		.slot          (got.slot),
		.issued_value_a(got.val_a),
		.issued_value_b(got.val_b),
		.issued_rob_id (got.rob),
		.issued_op_info(got.info),
		.has_free_slot (got.free)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one item to the predicted station and returns the result it should produce.
	function automatic outcome_t station_step(request_t rq);
		outcome_t res;
		logic     hit;
		int       i;
		res = '0;
		hit = 1'b0;
		case (rq.op)
			OP_ALLOC: begin
				for (i = 0; i < ENTRY_N && !hit; i++) begin
					if (!station[i].held) begin
						station[i] = {1'b1, rq.ready_a, rq.tag_a, rq.value_a, rq.ready_b,
							rq.tag_b, rq.value_b, rq.rob_id, rq.op_info};
						res.ok   = 1'b1;
						res.slot = slot_t'(i);
						hit      = 1'b1;
					end
				end
			end
			OP_WAKE: begin
				for (i = 0; i < ENTRY_N; i++) begin
					if (station[i].held) begin
						if (!station[i].rdy_a && station[i].tag_a == rq.result_tag) begin
							station[i].val_a = rq.result_value;
							station[i].rdy_a = 1'b1;
						end
						if (!station[i].rdy_b && station[i].tag_b == rq.result_tag) begin
							station[i].val_b = rq.result_value;
							station[i].rdy_b = 1'b1;
						end
					end
				end
			end
			OP_ISSUE: begin
				for (i = 0; i < ENTRY_N && !hit; i++) begin
					if (station[i].held && station[i].rdy_a && station[i].rdy_b) begin
						res.ok     = 1'b1;
						res.slot   = slot_t'(i);
						res.val_a  = station[i].val_a;
						res.val_b  = station[i].val_b;
						res.rob    = station[i].rob;
						res.info   = station[i].info;
						station[i] = '0;
						hit        = 1'b1;
					end
				end
			end
			default: begin
				for (i = 0; i < ENTRY_N; i++)
					station[i] = '0;
			end
		endcase
		for (i = 0; i < ENTRY_N; i++)
			if (!station[i].held)
				res.free = 1'b1;
		return res;
	endfunction

	function automatic request_t plain_rq(op_t code);
		request_t rq;
		rq    = '0;
		rq.op = code;
		return rq;
	endfunction

	function automatic request_t wake_rq(tag_t tag, val_t value);
		request_t rq;
		rq              = plain_rq(OP_WAKE);
		rq.result_tag   = tag;
		rq.result_value = value;
		return rq;
	endfunction

	function automatic request_t alloc_rq(tag_t ta, val_t va, logic ra, tag_t tb, val_t vb,
		logic rb, info_t info, rob_t rob);
		request_t rq;
		rq         = plain_rq(OP_ALLOC);
		rq.tag_a   = ta;
		rq.value_a = va;
		rq.ready_a = ra;
		rq.tag_b   = tb;
		rq.value_b = vb;
		rq.ready_b = rb;
		rq.op_info = info;
		rq.rob_id  = rob;
		return rq;
	endfunction

	function automatic outcome_t result_of(logic ok, slot_t s, val_t a, val_t b, rob_t r,
		info_t i, logic f);
		return {ok, s, a, b, r, i, f};
	endfunction

	// Tags mostly come from a narrow pool so that wakeups find waiting operands.
	function automatic tag_t random_tag();
		if ($urandom_range(0, 3) == 0)
			return tag_t'($urandom_range(0, 127));
		return tag_t'($urandom_range(0, 7));
	endfunction

	// Random item; most wakeups broadcast a tag that some entry is waiting for.
	function automatic request_t random_request();
		request_t rq;
		tag_t     waiting [$];
		int       pick;
		int       i;
		rq.tag_a        = random_tag();
		rq.value_a      = $urandom;
		rq.ready_a      = $urandom_range(0, 1) != 0;
		rq.tag_b        = random_tag();
		rq.value_b      = $urandom;
		rq.ready_b      = $urandom_range(0, 1) != 0;
		rq.op_info      = info_t'($urandom);
		rq.rob_id       = rob_t'($urandom_range(0, 31));
		rq.result_tag   = random_tag();
		rq.result_value = $urandom;
		pick            = $urandom_range(0, 99);
		if (pick < 2)
			rq.op = OP_FLUSH;
		else if (pick < 42)
			rq.op = OP_ALLOC;
		else if (pick < 72)
			rq.op = OP_WAKE;
		else
			rq.op = OP_ISSUE;
		if (rq.op == OP_WAKE) begin
			for (i = 0; i < ENTRY_N; i++) begin
				if (station[i].held && !station[i].rdy_a)
					waiting.push_back(station[i].tag_a);
				if (station[i].held && !station[i].rdy_b)
					waiting.push_back(station[i].tag_b);
			end
			if (waiting.size() != 0 && $urandom_range(0, 4) != 0)
				rq.result_tag = waiting[$urandom_range(0, waiting.size() - 1)];
		end
		return rq;
	endfunction

	// Offers one item after a random gap and records its expected result once taken.
	task automatic present_item(request_t rq, logic typed, outcome_t want);
		outcome_t predicted;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		stim  <= rq;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predicted = station_step(rq);
		awaited.push_back('{typed ? want : predicted, $realtime});
	endtask

	// Holds the sender off until every expected result has come back.
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (awaited.size() != 0);
	endtask

	task automatic report(string what, outcome_t want, outcome_t seen);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected ok=%0d slot=%0d a=%h b=%h rob=%0d info=%h free=%0d, ",
				$realtime, what, want.ok, want.slot, want.val_a, want.val_b, want.rob,
				want.info, want.free,
				"got ok=%0d slot=%0d a=%h b=%h rob=%0d info=%h free=%0d",
				seen.ok, seen.slot, seen.val_a, seen.val_b, seen.rob, seen.info, seen.free);
	endtask

	// Result checker: each strobed result is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (awaited.size() == 0 || awaited[0].at == $realtime) begin
				report("result with no item outstanding", UNTYPED, got);
			end else begin
				if (got.ok !== awaited[0].res.ok || got.slot !== awaited[0].res.slot ||
					got.val_a !== awaited[0].res.val_a || got.val_b !== awaited[0].res.val_b ||
					got.rob !== awaited[0].res.rob || got.info !== awaited[0].res.info ||
					got.free !== awaited[0].res.free)
					report("result mismatch", awaited[0].res, got);
				void'(awaited.pop_front());
			end
		end
	end

	// Watchdog on cycles in which neither an item nor a result is taken.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_MAX) begin
			@(posedge clk);
			if (!arst_n || (start === 1'b1 && busy === 1'b0) || done === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("No progress for %0d cycles", QUIET_MAX);
		$display("Regression FAIL");
		$finish;
	end

	// Main sequence: reset, directed table, random phases, final verdict.
	initial begin : stimulus
		int     r;
		int     k;
		int     ph;
		int     phase_idle [4];
		request_t fill;
		mismatches = 0;
		idle_pct   = 0;
		phase_idle = '{0, 60, 0, 36};
		arst_n <= 1'b0;
		start  <= 1'b0;
		stim   <= '0;
		for (k = 0; k < ENTRY_N; k++)
			station[k] = '0;

		fill = alloc_rq(7'h01, 32'h0000_0001, 1'b0, 7'h02, 32'h0000_0002, 1'b0, 26'h0, 5'h0);
		directed_rows = '{
			// Empty station: nothing to issue, wakeup and flush report only the free slot.
			{plain_rq(OP_ISSUE), 5'd1, 1'b1, result_of(0, 0, 0, 0, 0, 0, 1)},
			{wake_rq(7'h7f, 32'hffff_ffff), 5'd1, 1'b1, result_of(0, 0, 0, 0, 0, 0, 1)},
			{plain_rq(OP_FLUSH), 5'd1, 1'b1, result_of(0, 0, 0, 0, 0, 0, 1)},
			// Fully ready entry with extreme fields goes straight through.
			{alloc_rq(7'h7f, 32'hffff_ffff, 1'b1, 7'h7f, 32'h0, 1'b1, 26'h3ff_ffff, 5'h1f),
				5'd1, 1'b1, result_of(1, 0, 0, 0, 0, 0, 1)},
			{plain_rq(OP_ISSUE), 5'd1, 1'b1,
				result_of(1, 0, 32'hffff_ffff, 32'h0, 5'h1f, 26'h3ff_ffff, 1)},
			// Both operands awaiting the same tag, then mixed readiness.
			{alloc_rq(7'h05, 32'h0, 1'b0, 7'h05, 32'h0, 1'b0, 26'h0, 5'h00), 5'd1, 1'b0, UNTYPED},
			{alloc_rq(7'h00, 32'h0, 1'b0, 7'h33, 32'h5555_aaaa, 1'b1, 26'h2aa_aaaa, 5'h0a),
				5'd1, 1'b0, UNTYPED},
			{alloc_rq(7'h11, 32'haaaa_5555, 1'b1, 7'h7f, 32'h0, 1'b0, 26'h155_5555, 5'h15),
				5'd1, 1'b0, UNTYPED},
			{wake_rq(7'h05, 32'hdead_beef), 5'd1, 1'b0, UNTYPED},
			{wake_rq(7'h00, 32'h0000_0000), 5'd1, 1'b0, UNTYPED},
			{plain_rq(OP_ISSUE), 5'd1, 1'b0, UNTYPED},
			{wake_rq(7'h05, 32'h0f0f_0f0f), 5'd1, 1'b0, UNTYPED},
			{plain_rq(OP_ISSUE), 5'd1, 1'b0, UNTYPED},
			// Only a waiting entry remains, so issue finds nothing.
			{plain_rq(OP_ISSUE), 5'd1, 1'b0, UNTYPED},
			// The ready first operand must not take this broadcast.
			{wake_rq(7'h7f, 32'h1234_5678), 5'd1, 1'b0, UNTYPED},
			{plain_rq(OP_ISSUE), 5'd1, 1'b0, UNTYPED},
			{plain_rq(OP_FLUSH), 5'd1, 1'b1, result_of(0, 0, 0, 0, 0, 0, 1)},
			// Fill every slot, then allocate and issue against a full station.
			{fill, 5'd15, 1'b0, UNTYPED},
			{fill, 5'd1, 1'b1, result_of(1, 4'hf, 0, 0, 0, 0, 0)},
			{fill, 5'd1, 1'b1, result_of(0, 0, 0, 0, 0, 0, 0)},
			{plain_rq(OP_ISSUE), 5'd1, 1'b1, result_of(0, 0, 0, 0, 0, 0, 0)},
			{wake_rq(7'h01, 32'hcafe_f00d), 5'd1, 1'b0, UNTYPED},
			{wake_rq(7'h02, 32'h8765_4321), 5'd1, 1'b0, UNTYPED},
			{plain_rq(OP_ISSUE), 5'd1, 1'b0, UNTYPED},
			{plain_rq(OP_FLUSH), 5'd1, 1'b1, result_of(0, 0, 0, 0, 0, 0, 1)}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < $size(directed_rows); k++)
			for (r = 0; r < directed_rows[k].reps; r++)
				present_item(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].want);
		drain();

		// Random phases, each with its own sender idling, separated by a full drain.
		for (ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			for (k = 0; k < RAND_ITEMS / 4; k++)
				present_item(random_request(), 1'b0, UNTYPED);
			drain();
		end

		repeat (8) @(posedge clk);
		if (awaited.size() != 0) begin
			$display("%0d expected results never arrived", awaited.size());
			mismatches += awaited.size();
		end
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/rsws_pkg.sv
hdl/reservation_station_wakeup_select.sv
tb/sv/tb_top.sv
